FILE: rtl/core/iirs_pkg.sv
// shared constants for the summed-area table rectangle sum core
package iirs_pkg;

    // table geometry: column-major, address = column * height + row
    localparam int MAX_DIM     = 256;
    localparam int TABLE_AW    = 16;
    localparam int TABLE_DEPTH = MAX_DIM * MAX_DIM;

    // field widths
    localparam int DIM_W  = 9;
    localparam int OUT_W  = 32;
    localparam int IDX_W  = 2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // beat modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // term codes of one query, in issue order
    localparam logic [1:0] TERM_BR = 2'd0;  // bottom-right, added
    localparam logic [1:0] TERM_TR = 2'd1;  // above top-right, subtracted
    localparam logic [1:0] TERM_BL = 2'd2;  // left of bottom-left, subtracted
    localparam logic [1:0] TERM_TL = 2'd3;  // above-left corner, added

    // tag that travels with a table read through the pipeline
    typedef struct packed {
        logic valid;
        logic sub;
        logic last;
    } t_term_tag;

endpackage

FILE: rtl/core/integral_image_rect_sum_core.sv
// top level: summed-area table store and rectangle sum query engine
//
// Usage:
//   A beat is taken at a rising edge with start high and busy low.
//   i_mode = 0 writes i_entry_value to table address i_entry_address in
//   that cycle; no result follows and busy stays low.
//   i_mode = 1 queries the 1-based inclusive rectangle given by the four
//   corner ports. One result follows, shown for exactly one cycle with
//   o_result_valid high; the receiver cannot stall it.
//   A query outside the image returns o_region_sum = 0 and
//   o_out_of_bounds = 1 in the cycle after the beat, with no table read.
//   A valid query needs one, two or four table reads, issued one a cycle
//   on the single memory port; busy stays high until the last read has
//   been accumulated and the result is registered. The next beat may be
//   taken in the cycle the result is shown. The memory port sets the rate.
//   Image width and height are written through i_cfg_we / i_cfg_index /
//   i_cfg_wdata while idle. Reset sets both to 256 and clears all control
//   state; table contents are undefined until written.
module integral_image_rect_sum_core #(
    parameter int SUM_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // command channel
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_mode,
    input  logic [15:0]                  i_entry_address,
    input  logic [31:0]                  i_entry_value,
    input  logic [iirs_pkg::DIM_W-1:0]   i_left_column,
    input  logic [iirs_pkg::DIM_W-1:0]   i_top_row,
    input  logic [iirs_pkg::DIM_W-1:0]   i_right_column,
    input  logic [iirs_pkg::DIM_W-1:0]   i_bottom_row,
    // result channel
    output logic                         o_result_valid,
    output logic [iirs_pkg::OUT_W-1:0]   o_region_sum,
    output logic                         o_out_of_bounds,
    // configuration port
    input  logic                         i_cfg_we,
    input  logic [iirs_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [iirs_pkg::DIM_W-1:0]   i_cfg_wdata
);
    import iirs_pkg::*;

    // configuration
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;

    // query context (0-based coordinates)
    logic [DIM_W-1:0] r_row_hi;
    logic [DIM_W-1:0] r_row_lo;
    logic [DIM_W-1:0] r_col_hi;
    logic [DIM_W-1:0] r_col_lo;
    logic             r_has_top;
    logic             r_has_left;

    // term sequencer
    logic             r_busy;
    logic             r_gen_active;
    logic [1:0]       r_term;
    logic [1:0]       n_term;
    logic             w_gen_last;

    // address stage and read stage
    logic [TABLE_AW-1:0] r_addr;
    t_term_tag           r_a_tag;
    t_term_tag           r_d_tag;
    logic [SUM_BITS-1:0] w_rdata;

    // accumulator and result
    logic [SUM_BITS-1:0] r_acc;
    logic [SUM_BITS-1:0] w_acc_next;
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_sum;
    logic                r_out_oob;

    logic                w_accept;
    logic                w_query;
    logic                w_oob;
    logic [DIM_W-1:0]    w_row;
    logic [DIM_W-1:0]    w_col;
    logic                w_sub;
    logic [2*DIM_W-1:0]  w_prod;
    logic [TABLE_AW-1:0] w_gen_addr;
    logic [SUM_BITS+31:0] w_wext;
    logic [SUM_BITS+31:0] w_sext;

    assign w_accept = start && !r_busy;
    assign w_query  = w_accept && (i_mode == MODE_QUERY);

    // corner check against the configured image
    assign w_oob = (i_left_column == '0) || (i_top_row == '0) ||
                   (i_right_column == '0) || (i_bottom_row == '0) ||
                   (i_left_column > r_width) || (i_right_column > r_width) ||
                   (i_top_row > r_height) || (i_bottom_row > r_height);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(MAX_DIM);
            r_height <= DIM_W'(MAX_DIM);
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_IMAGE_WIDTH) begin
                r_width <= i_cfg_wdata;
            end else if (i_cfg_index == REG_IMAGE_HEIGHT) begin
                r_height <= i_cfg_wdata;
            end
        end
    end

    // next enabled term after the current one
    always_comb begin
        n_term     = r_term;
        w_gen_last = 1'b1;
        unique case (r_term)
            TERM_BR: begin
                if (r_has_top) begin
                    n_term     = TERM_TR;
                    w_gen_last = 1'b0;
                end else if (r_has_left) begin
                    n_term     = TERM_BL;
                    w_gen_last = 1'b0;
                end
            end
            TERM_TR: begin
                if (r_has_left) begin
                    n_term     = TERM_BL;
                    w_gen_last = 1'b0;
                end
            end
            TERM_BL: begin
                if (r_has_top) begin
                    n_term     = TERM_TL;
                    w_gen_last = 1'b0;
                end
            end
            default: begin
                n_term     = r_term;
                w_gen_last = 1'b1;
            end
        endcase
    end

    // term coordinates and table address
    always_comb begin
        w_row = ((r_term == TERM_BR) || (r_term == TERM_BL)) ? r_row_hi : r_row_lo;
        w_col = ((r_term == TERM_BR) || (r_term == TERM_TR)) ? r_col_hi : r_col_lo;
        w_sub = (r_term == TERM_TR) || (r_term == TERM_BL);
    end

    assign w_prod     = {{DIM_W{1'b0}}, w_col} * {{DIM_W{1'b0}}, r_height};
    assign w_gen_addr = w_prod[TABLE_AW-1:0] + TABLE_AW'(w_row);

    // query context capture and sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_gen_active <= 1'b0;
            r_term       <= TERM_BR;
            r_a_tag      <= '0;
            r_d_tag      <= '0;
        end else begin
            if (w_query && !w_oob) begin
                r_busy       <= 1'b1;
                r_gen_active <= 1'b1;
                r_term       <= TERM_BR;
            end else if (r_gen_active) begin
                r_gen_active <= !w_gen_last;
                r_term       <= n_term;
            end
            if (r_d_tag.valid && r_d_tag.last) begin
                r_busy <= 1'b0;
            end
            r_a_tag.valid <= r_gen_active;
            r_a_tag.sub   <= w_sub;
            r_a_tag.last  <= w_gen_last;
            r_d_tag       <= r_a_tag;
        end
    end

    // payload of the query context and address stage
    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_row_hi   <= i_bottom_row - DIM_W'(1);
            r_row_lo   <= i_top_row - DIM_W'(2);
            r_col_hi   <= i_right_column - DIM_W'(1);
            r_col_lo   <= i_left_column - DIM_W'(2);
            r_has_top  <= i_top_row > DIM_W'(1);
            r_has_left <= i_left_column > DIM_W'(1);
        end
        if (r_gen_active) begin
            r_addr <= w_gen_addr;
        end
    end

    // table memory; writes only happen while no query is in flight
    assign w_wext = {{SUM_BITS{1'b0}}, i_entry_value};

    iirs_table #(
        .DATA_W (SUM_BITS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_accept && (i_mode == MODE_WRITE)),
        .i_re    (r_a_tag.valid),
        .i_addr  (w_accept ? i_entry_address : r_addr),
        .i_wdata (w_wext[SUM_BITS-1:0]),
        .o_rdata (w_rdata)
    );

    // accumulate read terms
    assign w_acc_next = r_d_tag.sub ? (r_acc - w_rdata) : (r_acc + w_rdata);
    assign w_sext     = {32'b0, w_acc_next};

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_acc <= '0;
        end else if (r_d_tag.valid) begin
            r_acc <= w_acc_next;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (w_query && w_oob) || (r_d_tag.valid && r_d_tag.last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_query && w_oob) begin
            r_out_sum <= '0;
            r_out_oob <= 1'b1;
        end else if (r_d_tag.valid && r_d_tag.last) begin
            r_out_sum <= w_sext[OUT_W-1:0];
            r_out_oob <= 1'b0;
        end
    end

    assign busy            = r_busy;
    assign o_result_valid  = r_out_valid;
    assign o_region_sum    = r_out_sum;
    assign o_out_of_bounds = r_out_oob;

endmodule

FILE: rtl/core/iirs_table.sv
// single-port table memory with registered read data
module iirs_table #(
    parameter int DATA_W = 32
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic                         i_re,
    input  logic [iirs_pkg::TABLE_AW-1:0] i_addr,
    input  logic [DATA_W-1:0]            i_wdata,
    output logic [DATA_W-1:0]            o_rdata
);
    import iirs_pkg::*;

    logic [DATA_W-1:0] r_mem [TABLE_DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // one access per cycle, write has priority
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: bench/integral_image_rect_sum_core_tb.sv
// testbench for the summed-area table rectangle sum core
`timescale 1ns / 1ps

module integral_image_rect_sum_core_tb;
    import iirs_pkg::*;

    // register indexes with no register behind them
    localparam logic [IDX_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [IDX_W-1:0] REG_UNUSED_B = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int TIMEOUT_NS    = 400_000;

    typedef struct packed {
        logic             mode;
        logic [15:0]      address;
        logic [31:0]      value;
        logic [DIM_W-1:0] left_col;
        logic [DIM_W-1:0] top_row;
        logic [DIM_W-1:0] right_col;
        logic [DIM_W-1:0] bottom_row;
    } t_cmd_beat;

    typedef struct packed {
        logic [OUT_W-1:0] sum;
        logic             oob;
    } t_rect_result;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic             i_mode = MODE_WRITE;
    logic [15:0]      i_entry_address = '0;
    logic [31:0]      i_entry_value = '0;
    logic [DIM_W-1:0] i_left_column = '0;
    logic [DIM_W-1:0] i_top_row = '0;
    logic [DIM_W-1:0] i_right_column = '0;
    logic [DIM_W-1:0] i_bottom_row = '0;
    logic             o_result_valid;
    logic [OUT_W-1:0] o_region_sum;
    logic             o_out_of_bounds;
    logic             i_cfg_we = 1'b0;
    logic [IDX_W-1:0] i_cfg_index = '0;
    logic [DIM_W-1:0] i_cfg_wdata = '0;

    // mirror of the table and the geometry registers
    logic [OUT_W-1:0] sat_model [TABLE_DEPTH];
    bit               sat_written [TABLE_DEPTH];
    logic [DIM_W-1:0] dim_width = 9'd256;
    logic [DIM_W-1:0] dim_height = 9'd256;
    t_rect_result     sum_queue [$];
    int               idle_pct = 0;
    int               beats_sent = 0;
    int               errors = 0;

    integral_image_rect_sum_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_entry_address (i_entry_address),
        .i_entry_value   (i_entry_value),
        .i_left_column   (i_left_column),
        .i_top_row       (i_top_row),
        .i_right_column  (i_right_column),
        .i_bottom_row    (i_bottom_row),
        .o_result_valid  (o_result_valid),
        .o_region_sum    (o_region_sum),
        .o_out_of_bounds (o_out_of_bounds),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // table address of a 0-based cell, column-major, wrapped to the table
    function automatic logic [15:0] cell_addr(input int row, input int col);
        int flat;
        flat = col * int'(dim_height) + row;
        return flat[15:0];
    endfunction

    // table reads of a rectangle, ordered add, subtract, subtract, add;
    // an empty mask means a corner lies outside the image
    function automatic logic [3:0] rect_reads(input logic [DIM_W-1:0] c1, r1, c2, r2,
                                              output logic [3:0][15:0] addr);
        int x1, y1, x2, y2;
        logic [3:0] mask;
        x1 = int'(c1);
        y1 = int'(r1);
        x2 = int'(c2);
        y2 = int'(r2);
        addr = '0;
        if (x1 < 1 || y1 < 1 || x2 < 1 || y2 < 1
            || x1 > int'(dim_width) || x2 > int'(dim_width)
            || y1 > int'(dim_height) || y2 > int'(dim_height))
            return 4'b0000;
        mask[0] = 1'b1;
        mask[1] = (y1 > 1);
        mask[2] = (x1 > 1);
        mask[3] = (y1 > 1) && (x1 > 1);
        addr[0] = cell_addr(y2 - 1, x2 - 1);
        addr[1] = cell_addr(y1 - 2, x2 - 1);
        addr[2] = cell_addr(y2 - 1, x1 - 2);
        addr[3] = cell_addr(y1 - 2, x1 - 2);
        return mask;
    endfunction

    // rectangle sum from the mirrored table, wrapping modulo 2^32
    function automatic t_rect_result predict_rect_sum(input t_cmd_beat b);
        logic [3:0][15:0] addr;
        logic [3:0] mask;
        t_rect_result res;
        mask = rect_reads(b.left_col, b.top_row, b.right_col, b.bottom_row, addr);
        res.oob = (mask == 4'b0000);
        res.sum = '0;
        if (!res.oob) begin
            res.sum = sat_model[addr[0]];
            if (mask[1]) res.sum -= sat_model[addr[1]];
            if (mask[2]) res.sum -= sat_model[addr[2]];
            if (mask[3]) res.sum += sat_model[addr[3]];
        end
        return res;
    endfunction

    // beat with random content in every field but mode, which is set to write
    function automatic t_cmd_beat junk_beat();
        t_cmd_beat b;
        b.mode       = MODE_WRITE;
        b.address    = 16'($urandom());
        b.value      = $urandom();
        b.left_col   = DIM_W'($urandom());
        b.top_row    = DIM_W'($urandom());
        b.right_col  = DIM_W'($urandom());
        b.bottom_row = DIM_W'($urandom());
        return b;
    endfunction

    // drive one beat after a random gap, wait for it to be taken, then update the mirror or predict
    task automatic send_beat(input t_cmd_beat b);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start           <= 1'b1;
        i_mode          <= b.mode;
        i_entry_address <= b.address;
        i_entry_value   <= b.value;
        i_left_column   <= b.left_col;
        i_top_row       <= b.top_row;
        i_right_column  <= b.right_col;
        i_bottom_row    <= b.bottom_row;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (b.mode == MODE_WRITE) begin
            sat_model[b.address]   = b.value;
            sat_written[b.address] = 1'b1;
        end else begin
            sum_queue.push_back(predict_rect_sum(b));
        end
        beats_sent++;
    endtask

    task automatic put_entry(input logic [15:0] addr, input logic [31:0] value);
        t_cmd_beat b;
        b = junk_beat();
        b.address = addr;
        b.value   = value;
        send_beat(b);
    endtask

    // query a rectangle, first writing any cell it reads that holds no value yet
    task automatic query_rect(input int c1, r1, c2, r2);
        t_cmd_beat b;
        logic [3:0][15:0] addr;
        logic [3:0] mask;
        mask = rect_reads(DIM_W'(c1), DIM_W'(r1), DIM_W'(c2), DIM_W'(r2), addr);
        for (int i = 0; i < 4; i++)
            if (mask[i] && !sat_written[addr[i]]) put_entry(addr[i], $urandom());
        b = junk_beat();
        b.mode       = MODE_QUERY;
        b.left_col   = DIM_W'(c1);
        b.top_row    = DIM_W'(r1);
        b.right_col  = DIM_W'(c2);
        b.bottom_row = DIM_W'(r2);
        send_beat(b);
    endtask

    // hold off new beats until every predicted sum has come back
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (sum_queue.size() != 0) @(posedge i_clk);
    endtask

    // register write, only once the core is idle
    task automatic cfg_write(input logic [IDX_W-1:0] idx, input int data);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= DIM_W'(data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:  dim_width = DIM_W'(data);
            REG_IMAGE_HEIGHT: dim_height = DIM_W'(data);
            default: ;
        endcase
    endtask

    task automatic set_dims(input int w, input int h);
        cfg_write(REG_IMAGE_WIDTH, w);
        cfg_write(REG_IMAGE_HEIGHT, h);
    endtask

    // reset geometry: far corner, last row and column, first cell, wrap, inverted columns
    task automatic test_reset_geometry();
        put_entry(cell_addr(255, 255), 32'hFFFF_FFFF);
        put_entry(cell_addr(254, 255), 32'h0000_0001);
        put_entry(cell_addr(255, 254), 32'h8000_0000);
        put_entry(cell_addr(254, 254), 32'h0000_0000);
        put_entry(cell_addr(255, 253), 32'h0000_0005);
        put_entry(cell_addr(0, 0), 32'h1234_5678);
        query_rect(1, 1, 256, 256);
        query_rect(256, 256, 256, 256);
        query_rect(1, 256, 256, 256);
        query_rect(256, 1, 256, 256);
        query_rect(1, 1, 1, 1);
        query_rect(256, 1, 254, 256);
    endtask

    // corners below one or past the image edge
    task automatic test_out_of_image();
        query_rect(0, 1, 1, 1);
        query_rect(1, 0, 1, 1);
        query_rect(1, 1, 0, 0);
        query_rect(257, 1, 1, 257);
        query_rect(511, 511, 511, 511);
    endtask

    // writes to unmapped indexes leave the geometry alone
    task automatic test_unused_registers();
        cfg_write(REG_UNUSED_A, 3);
        cfg_write(REG_UNUSED_B, 0);
        query_rect(256, 256, 256, 256);
    endtask

    // a zero dimension puts every corner outside the image
    task automatic test_zero_dims();
        set_dims(0, 256);
        query_rect(1, 1, 1, 1);
        set_dims(256, 0);
        query_rect(1, 1, 1, 1);
    endtask

    // dimensions past the table size, addresses wrap around
    task automatic test_oversized_dims();
        set_dims(511, 511);
        query_rect(511, 511, 511, 511);
        query_rect(1, 1, 511, 511);
    endtask

    // random writes and queries under one geometry and one idle rate
    task automatic test_random_mix(input int w, input int h, input int pct, input int count);
        int base_count;
        int pick;
        set_dims(w, h);
        idle_pct = pct;
        base_count = beats_sent;
        while (beats_sent - base_count < count) begin
            pick = $urandom_range(99);
            if (pick < 55)
                query_rect($urandom_range(w, 1), $urandom_range(h, 1),
                           $urandom_range(w, 1), $urandom_range(h, 1));
            else if (pick < 85)
                put_entry(16'($urandom()), $urandom());
            else if (pick < 97)
                query_rect($urandom_range(511), $urandom_range(511),
                           $urandom_range(511), $urandom_range(511));
            else
                drain_results();
        end
    endtask

    // compare each result beat with the oldest predicted sum
    always @(posedge i_clk) begin : check_results
        t_rect_result want;
        if (i_rst_n && o_result_valid === 1'b1) begin
            if (sum_queue.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual sum %h oob %b",
                         $time, o_region_sum, o_out_of_bounds);
            end else begin
                want = sum_queue.pop_front();
                if (o_region_sum !== want.sum) begin
                    errors++;
                    $display("%0t: region_sum mismatch, expected %h actual %h",
                             $time, want.sum, o_region_sum);
                end
                if (o_out_of_bounds !== want.oob) begin
                    errors++;
                    $display("%0t: out_of_bounds mismatch, expected %b actual %b",
                             $time, want.oob, o_out_of_bounds);
                end
            end
        end
    end

    // test sequence
    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        idle_pct = 18;
        test_reset_geometry();
        test_out_of_image();
        test_unused_registers();
        test_zero_dims();
        test_oversized_dims();
        test_random_mix(4, 3, 0, 250);
        test_random_mix(1, 1, 69, 100);
        test_random_mix(17, 9, 69, 250);
        test_random_mix(256, 256, 18, 200);
        test_random_mix(511, 511, 18, 150);
        test_random_mix(1, 256, 0, 150);
        test_random_mix(40, 33, 69, 200);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/iirs_pkg.sv
rtl/core/iirs_table.sv
rtl/core/integral_image_rect_sum_core.sv
bench/integral_image_rect_sum_core_tb.sv
